FILE: design/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg - shared types and constants for the sparse column Laplacian builder
// Word formats of both channels, hold buffer sizing and value helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package scl_pkg;

  // Hold buffer sizing
  localparam int MAX_COLUMN_ENTRIES = 63;
  localparam int HOLD_AW            = $clog2(MAX_COLUMN_ENTRIES);
  localparam int HOLD_CW            = $clog2(MAX_COLUMN_ENTRIES + 1);

  typedef logic [HOLD_AW-1:0] hold_addr_t;
  typedef logic [HOLD_CW-1:0] hold_cnt_t;

  localparam hold_cnt_t HOLD_FULL = hold_cnt_t'(MAX_COLUMN_ENTRIES);

  // Q16.16 one, and the signed 40-bit degree range
  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [39:0] DEG_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] DEG_MIN = 40'sh80_0000_0000;

  // Input word
  typedef struct packed {
    logic [15:0]        column_index;
    logic [15:0]        row_index;
    logic signed [31:0] entry_value;
    logic               entry_present;
    logic               last_in_column;
  } scl_in_t;

  // Result word
  typedef struct packed {
    logic [15:0]        out_column;
    logic [15:0]        out_row;
    logic signed [39:0] out_value;
    logic               out_last;
    logic               column_overflow;
  } scl_out_t;

  // One held entry
  typedef struct packed {
    logic [15:0]        row;
    logic signed [31:0] weight;
  } hold_entry_t;

  // Minus a 32-bit weight, widened to 40 bits
  function automatic logic signed [39:0] neg_weight(input logic signed [31:0] w);
    logic signed [39:0] wx;
    wx = {{8{w[31]}}, w};
    return -wx;
  endfunction

  // Degree plus a weight, saturated to the signed 40-bit range
  function automatic logic signed [39:0] sat_add(input logic signed [39:0] d,
                                                 input logic signed [31:0] w);
    logic signed [40:0] s;
    s = {d[39], d} + {{9{w[31]}}, w};
    if (s[40] != s[39]) begin
      return s[40] ? DEG_MIN : DEG_MAX;
    end
    return s[39:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/scl_hold_mem.sv
// ----------------------------------------------------------------------------
// scl_hold_mem - hold buffer for the below-diagonal entries of a column
// One write port, one read port, registered read data.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module scl_hold_mem (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire scl_pkg::hold_addr_t wr_addr,
  input  wire scl_pkg::hold_entry_t wr_data,
  input  wire logic                rd_en,
  input  wire scl_pkg::hold_addr_t rd_addr,
  output      scl_pkg::hold_entry_t rd_data
);
  import scl_pkg::*;

  hold_entry_t mem [MAX_COLUMN_ENTRIES];
  hold_entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: design/sparse_column_laplacian_builder.sv
// ----------------------------------------------------------------------------
// sparse_column_laplacian_builder - graph Laplacian columns from a CSC stream
// Takes one stored matrix entry per input word and returns the Laplacian
// column: off-diagonal entries negated, the degree on the diagonal.
//
// Usage:
//   Input words arrive on in_valid/in_stall/in_data, column by column, rows
//   ascending. A word with last_in_column set, or with entry_present clear,
//   closes the column. Result words leave on out_valid/out_stall/out_data.
//   cfg_wr_en/cfg_wr_data write the weighting mode (reset 1) while the block
//   idles.
// Timing:
//   Entries above the diagonal leave in the cycle after acceptance. Words
//   that open or continue a column are taken back to back while the output
//   slot is free. A closing word leads to the diagonal state, which emits the
//   degree, then the held entries in arrival order. The drain rate is set by
//   the hold buffer read port: one entry per cycle unless out_stall holds the
//   result word. No input word is taken while the column is being drained.
// Reset and stall:
//   rst_n (synchronous) empties the column state and the output register;
//   the hold buffer needs no clearing pass. When out_stall is high while a
//   result word is valid, it holds, the drain pauses and in_stall is raised.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_column_laplacian_builder (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire scl_pkg::scl_in_t in_data,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      scl_pkg::scl_out_t out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_wr_data
);
  import scl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DIAG  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic               weight_mode_r;
  hold_cnt_t          held_count_r, held_count_nxt;
  logic signed [39:0] degree_r, degree_nxt;
  logic               diag_r, diag_nxt;
  logic               ovf_r, ovf_nxt;
  logic [15:0]        col_r;
  hold_addr_t         drain_idx_r, drain_idx_nxt;
  logic               out_valid_r;
  scl_out_t           out_data_r, out_data_nxt;

  logic               can_load;
  logic               load;
  logic               accept;
  logic signed [31:0] weight;
  logic               is_below;
  logic               is_first_diag;
  logic               is_hold;
  logic               close;
  logic               last_held;
  logic               mem_wr_en;
  hold_entry_t        mem_wr_data;
  logic               mem_rd_en;
  hold_addr_t         mem_rd_addr;
  hold_entry_t        mem_rd_data;

  // Output slot is free when empty or being taken this cycle
  assign can_load = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && can_load);
  assign accept   = in_valid && !in_stall;

  // Classify the incoming entry
  assign weight        = weight_mode_r ? in_data.entry_value : Q_ONE;
  assign is_below      = in_data.entry_present && !diag_r &&
                         (in_data.row_index < in_data.column_index);
  assign is_first_diag = in_data.entry_present && !diag_r &&
                         (in_data.row_index == in_data.column_index);
  assign is_hold       = in_data.entry_present &&
                         (in_data.row_index != in_data.column_index) &&
                         (diag_r || (in_data.row_index > in_data.column_index));
  assign close         = !in_data.entry_present || in_data.last_in_column;
  assign last_held     = (hold_cnt_t'(drain_idx_r) + hold_cnt_t'(1)) == held_count_r;

  // Hold buffer write: only while idle, so never against a pending read
  assign mem_wr_en   = accept && is_hold && (held_count_r != HOLD_FULL);
  assign mem_wr_data = '{row: in_data.row_index, weight: weight};

  scl_hold_mem u_hold_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (held_count_r[HOLD_AW-1:0]),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Column state, drain sequencing and result selection
  always_comb begin
    state_nxt      = state_r;
    held_count_nxt = held_count_r;
    degree_nxt     = degree_r;
    diag_nxt       = diag_r;
    ovf_nxt        = ovf_r;
    drain_idx_nxt  = drain_idx_r;
    load           = 1'b0;
    out_data_nxt   = out_data_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = drain_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_below) begin
            degree_nxt   = sat_add(degree_r, weight);
            load         = 1'b1;
            out_data_nxt = '{out_column:      in_data.column_index,
                             out_row:         in_data.row_index,
                             out_value:       neg_weight(weight),
                             out_last:        1'b0,
                             column_overflow: ovf_r};
          end
          if (is_first_diag) begin
            diag_nxt = 1'b1;
          end
          if (is_hold) begin
            diag_nxt = 1'b1;
            if (held_count_r != HOLD_FULL) begin
              held_count_nxt = held_count_r + hold_cnt_t'(1);
              degree_nxt     = sat_add(degree_r, weight);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (close) begin
            state_nxt = ST_DIAG;
          end
        end
      end
      ST_DIAG: begin
        if (can_load) begin
          load         = 1'b1;
          out_data_nxt = '{out_column:      col_r,
                           out_row:         col_r,
                           out_value:       degree_r,
                           out_last:        (held_count_r == '0),
                           column_overflow: ovf_r};
          if (held_count_r == '0) begin
            state_nxt  = ST_IDLE;
            degree_nxt = '0;
            diag_nxt   = 1'b0;
            ovf_nxt    = 1'b0;
          end else begin
            mem_rd_en     = 1'b1;
            mem_rd_addr   = '0;
            drain_idx_nxt = '0;
            state_nxt     = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (can_load) begin
          load         = 1'b1;
          out_data_nxt = '{out_column:      col_r,
                           out_row:         mem_rd_data.row,
                           out_value:       neg_weight(mem_rd_data.weight),
                           out_last:        last_held,
                           column_overflow: ovf_r};
          if (last_held) begin
            state_nxt      = ST_IDLE;
            held_count_nxt = '0;
            degree_nxt     = '0;
            diag_nxt       = 1'b0;
            ovf_nxt        = 1'b0;
          end else begin
            mem_rd_en     = 1'b1;
            mem_rd_addr   = drain_idx_r + hold_addr_t'(1);
            drain_idx_nxt = drain_idx_r + hold_addr_t'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      weight_mode_r <= 1'b1;
      held_count_r  <= '0;
      degree_r      <= '0;
      diag_r        <= 1'b0;
      ovf_r         <= 1'b0;
      drain_idx_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_count_r <= held_count_nxt;
      degree_r     <= degree_nxt;
      diag_r       <= diag_nxt;
      ovf_r        <= ovf_nxt;
      drain_idx_r  <= drain_idx_nxt;
      if (cfg_wr_en) begin
        weight_mode_r <= cfg_wr_data;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold column label and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      col_r <= in_data.column_index;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Buffer never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r <= HOLD_FULL)
    else $error("hold count beyond buffer depth");

  // Drain index stays inside the filled part of the buffer
  a_drain_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (hold_cnt_t'(drain_idx_r) < held_count_r))
    else $error("drain index past fill count");

  // Buffer is written only while idle, never against a drain read
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> ((state_r == ST_IDLE) && !mem_rd_en))
    else $error("hold buffer written outside idle");

  // A column's final word leaves the column state empty
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_data_nxt.out_last) |=>
      ((state_r == ST_IDLE) && (held_count_r == '0) && !diag_r && !ovf_r))
    else $error("column state not cleared after final word");

  // Result register loads only when its slot is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_data) && out_valid))
    else $error("stalled result word changed");

endmodule

`default_nettype wire
